// ===== design/hdcnb_pkg.sv =====
// Shared types, constants and the item-vector generator for the n-gram encoder.
// No dependencies; imported by every module of the block.
package hdcnb_pkg;

   localparam int MAX_DIM     = 8192;  // largest supported vector width
   localparam int SYM_W       = 5;     // symbol field
   localparam int WIDX_W      = 5;     // word_index field
   localparam int CFG_W       = 4;     // ngram_len register
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_W-1:0] NGRAM_LEN_RESET = 4'd5;

   // register index = paddr / 4
   localparam logic [CSR_ADDR_W-3:0] REG_NGRAM_LEN = 1'b0;

   // xorshift128 seeds
   localparam logic [31:0] SEED_X = 32'd123456789;
   localparam logic [31:0] SEED_Y = 32'd362436069;
   localparam logic [31:0] SEED_Z = 32'd521288629;
   localparam logic [31:0] SEED_W = 32'd88675123;

   // window stage -> counting stage
   typedef struct packed {
      logic vld;     // an item sits in the stage
      logic formed;  // window full, n-gram vector is live
      logic last;    // final symbol of the text
   } ng_ctl_type;

   // counting stage -> result buffer
   typedef struct packed {
      logic load;
      logic overflow;
   } res_ld_type;

   // Item vector of symbol sym for a dim-bit space, word 0 in the low bits.
   // Evaluated at elaboration only.
   function automatic logic [MAX_DIM-1:0] item_vec(input int unsigned sym,
                                                   input int unsigned dim);
      logic [31:0]      x;
      logic [31:0]      y;
      logic [31:0]      z;
      logic [31:0]      w;
      logic [31:0]      t;
      logic [MAX_DIM-1:0] v;
      int unsigned      words;
      int unsigned      first;
      x     = SEED_X;
      y     = SEED_Y;
      z     = SEED_Z;
      w     = SEED_W;
      v     = '0;
      words = dim >> 5;
      first = sym * words;
      if (first == 0) v[31:0] = w;
      for (int unsigned i = 1; i < first + words; i++) begin
         t = x ^ (x << 11);
         x = y;
         y = z;
         z = w;
         w = (w ^ (w >> 19)) ^ (t ^ (t >> 8));
         if (i >= first) v[(i - first) * 32 +: 32] = w;
      end
      return v;
   endfunction

endpackage

// ===== design/hdc_ngram_encode_bundle_core.sv =====
// Top level of the hyperdimensional n-gram encoder / majority bundler.
// Depends on hdcnb_pkg, hdcnb_ngram, hdcnb_bundle, hdcnb_out.
//
//  port group | dir | width  | carries
//  -----------+-----+--------+---------------------------------------------
//  req_*      | in  | 8+1    | one symbol per item, tlast on final symbol
//  rsp_*      | out | 40+1+1 | one 32-bit result word per item
//  csr_*      | in  | 3/32   | ngram_len register at byte address 0
//
// Throughput: one symbol per cycle while the pipe is not held (see below). After a
// text's last symbol is taken it passes the input register and the window stage
// register, is loaded into the result buffer, which raises rsp_tvalid; then DIM/32
// words go out at one per cycle (rsp_tready permitting).
// The result buffer holds one vector; a second text's last symbol waits in
// the counting stage (req_tready low) until the previous result has drained.
// Reset: synchronous, active high; the item table is constant logic, so no
// clearing pass follows reset.
module hdc_ngram_encode_bundle_core #(
   parameter int DIM        = 1024,
   parameter int SYMBOLS    = 27,
   parameter int MAX_NGRAM  = 8,
   parameter int COUNT_BITS = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [4:0] symbol, [7:5] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hdcnb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                               req_tlast,
   // rsp_tdata: [31:0] word, [36:32] word_index, [39:37] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hdcnb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   // rsp_tuser: [0] overflow
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hdcnb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hdcnb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hdcnb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import hdcnb_pkg::*;

   logic [CFG_W-1:0]          len_ff;
   logic [CSR_ADDR_W-3:0]     reg_idx;
   logic                      csr_wr;
   logic                      en;
   logic                      in_acc;
   logic [DIM-1:0]            ng_vec;
   ng_ctl_type                ng_ctl;
   logic [DIM-1:0]            maj;
   res_ld_type                res_ld;
   logic                      busy;
   logic [31:0]               out_word;
   logic [WIDX_W-1:0]         out_index;

   // ---- configuration port ----
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset)                                  len_ff <= NGRAM_LEN_RESET;
      else if (csr_wr && reg_idx == REG_NGRAM_LEN) len_ff <= csr_pwdata[CFG_W-1:0];
   end

   assign csr_prdata = (reg_idx == REG_NGRAM_LEN) ? CSR_DATA_W'(len_ff) : '0;

   // ---- pipeline control ----
   // The whole pipe holds only when a last symbol reaches the counting stage
   // while the result buffer is still streaming the previous text.
   assign en         = ~(ng_ctl.vld & ng_ctl.last & busy);
   assign req_tready = en;
   assign in_acc     = req_tvalid & en;

   hdcnb_ngram #(
      .DIM       (DIM),
      .SYMBOLS   (SYMBOLS),
      .MAX_NGRAM (MAX_NGRAM)
   ) u_ngram (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_acc  (in_acc),
      .in_sym  (req_tdata[SYM_W-1:0]),
      .in_last (req_tlast),
      .len_cfg (len_ff),
      .ng_vec  (ng_vec),
      .ng_ctl  (ng_ctl)
   );

   hdcnb_bundle #(
      .DIM        (DIM),
      .SYMBOLS    (SYMBOLS),
      .COUNT_BITS (COUNT_BITS)
   ) u_bundle (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .ng_vec (ng_vec),
      .ng_ctl (ng_ctl),
      .maj    (maj),
      .res_ld (res_ld)
   );

   hdcnb_out #(
      .DIM (DIM)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .maj       (maj),
      .res_ld    (res_ld),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (out_word),
      .out_index (out_index),
      .out_last  (rsp_tlast),
      .out_ovf   (rsp_tuser),
      .busy      (busy)
   );

   assign rsp_tdata = {3'b000, out_index, out_word};

endmodule

// ===== design/hdcnb_ngram.sv =====
// Input register, symbol window and n-gram vector build (XOR of rotated items).
// Depends on hdcnb_pkg.
module hdcnb_ngram #(
   parameter int DIM       = 1024,
   parameter int SYMBOLS   = 27,
   parameter int MAX_NGRAM = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_acc,
   input  logic [hdcnb_pkg::SYM_W-1:0]   in_sym,
   input  logic                          in_last,
   input  logic [hdcnb_pkg::CFG_W-1:0]   len_cfg,
   output logic [DIM-1:0]                ng_vec,
   output hdcnb_pkg::ng_ctl_type         ng_ctl
);
   import hdcnb_pkg::*;

   localparam int LW = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;
   localparam int FW = $clog2(MAX_NGRAM + 1);
   localparam logic [FW-1:0] FMAX = FW'(MAX_NGRAM);

   logic              in_vld_ff;
   logic [SYM_W-1:0]  sym_ff;
   logic              last_ff;
   logic [SYM_W-1:0]  hist_ff [MAX_NGRAM];
   logic [SYM_W-1:0]  hist_in [MAX_NGRAM];
   logic [FW-1:0]     fill_ff;
   logic [FW-1:0]     fill_in;
   logic [FW-1:0]     len_eff;
   logic              formed;
   logic [DIM-1:0]    item_tab [SYMBOLS];
   logic [DIM-1:0]    term [MAX_NGRAM];
   logic [DIM-1:0]    acc;
   logic [2*DIM-1:0]  acc_dbl;
   logic [LW-1:0]     rot;
   logic [DIM-1:0]    vec;
   logic [DIM-1:0]    ng_ff;
   ng_ctl_type        ctl_ff;

   // constant item table
   for (genvar s = 0; s < SYMBOLS; s++) begin : g_item
      localparam logic [MAX_DIM-1:0] IV = item_vec(s, DIM);
      assign item_tab[s] = IV[DIM-1:0];
   end

   always_comb begin
      if (len_cfg == '0)                  len_eff = FW'(1);
      else if (32'(len_cfg) > MAX_NGRAM)  len_eff = FMAX;
      else                                len_eff = FW'(len_cfg);
   end

   always_comb begin
      hist_in[0] = sym_ff;
      for (int k = 1; k < MAX_NGRAM; k++) hist_in[k] = hist_ff[k-1];
   end

   assign fill_in = (fill_ff == FMAX) ? fill_ff : fill_ff + FW'(1);
   assign formed  = (fill_in >= len_eff);

   // history slot k (0 = newest) is rotated left by k; the sum is then
   // rotated right by len-1, which puts the oldest slot at rotation 0
   for (genvar k = 0; k < MAX_NGRAM; k++) begin : g_slot
      logic [DIM-1:0]   vk;
      logic [2*DIM-1:0] vdbl;
      always_comb begin
         vk = '0;
         for (int s = 0; s < SYMBOLS; s++)
            if (32'(hist_in[k]) == s) vk = item_tab[s];
      end
      assign vdbl    = {vk, vk};
      assign term[k] = (32'(len_eff) > k) ? vdbl[DIM-k +: DIM] : '0;
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < MAX_NGRAM; k++) acc = acc ^ term[k];
   end

   assign acc_dbl = {acc, acc};
   assign rot     = LW'(len_eff - FW'(1));
   assign vec     = acc_dbl[rot +: DIM];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         ctl_ff    <= '0;
         fill_ff   <= '0;
         for (int k = 0; k < MAX_NGRAM; k++) hist_ff[k] <= '0;
      end else if (en) begin
         in_vld_ff     <= in_acc;
         ctl_ff.vld    <= in_vld_ff;
         ctl_ff.formed <= in_vld_ff & formed;
         ctl_ff.last   <= in_vld_ff & last_ff;
         if (in_vld_ff) begin
            fill_ff <= last_ff ? '0 : fill_in;
            for (int k = 0; k < MAX_NGRAM; k++)
               hist_ff[k] <= last_ff ? '0 : hist_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sym_ff  <= in_sym;
         last_ff <= in_last;
         if (in_vld_ff) ng_ff <= vec;
      end
   end

   assign ng_vec = ng_ff;
   assign ng_ctl = ctl_ff;

endmodule

// ===== design/hdcnb_bundle.sv =====
// Per-dimension saturating counters, n-gram count, tail item and majority vote.
// Depends on hdcnb_pkg.
module hdcnb_bundle #(
   parameter int DIM        = 1024,
   parameter int SYMBOLS    = 27,
   parameter int COUNT_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [DIM-1:0]         ng_vec,
   input  hdcnb_pkg::ng_ctl_type  ng_ctl,
   output logic [DIM-1:0]         maj,
   output hdcnb_pkg::res_ld_type  res_ld
);
   import hdcnb_pkg::*;

   localparam int CW1 = COUNT_BITS + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
   localparam logic [MAX_DIM-1:0] TAIL_FULL = item_vec(SYMBOLS - 1, DIM);

   logic                  commit;
   logic                  add_ng;
   logic                  add_tail;
   logic [COUNT_BITS-1:0] n_ff;
   logic [COUNT_BITS-1:0] n_mid;
   logic [COUNT_BITS-1:0] n_fin;
   logic [COUNT_BITS-1:0] thr;
   logic                  ovf_ff;
   logic                  ovf_fin;

   assign commit = en & ng_ctl.vld;
   assign add_ng = ng_ctl.formed;

   // on a text's last symbol, the tail item goes in when the count, after this n-gram, is even
   assign n_mid    = (add_ng && n_ff != CMAX) ? n_ff + COUNT_BITS'(1) : n_ff;
   assign add_tail = ng_ctl.last & ~n_mid[0];
   assign n_fin    = (add_tail && n_mid != CMAX) ? n_mid + COUNT_BITS'(1) : n_mid;
   assign thr      = n_fin >> 1;

   // a bit counter never exceeds the n-gram count, so it can only hit the
   // limit when the n-gram count does: the count alone flags overflow
   assign ovf_fin = ovf_ff | (add_ng & (n_ff == CMAX)) | (add_tail & (n_mid == CMAX));

   for (genvar gi = 0; gi < DIM; gi++) begin : g_lane
      logic [1:0]            inc;
      logic [CW1-1:0]        sum;
      logic [COUNT_BITS-1:0] cfin;
      logic [COUNT_BITS-1:0] cnt_ff;
      assign inc     = 2'(add_ng & ng_vec[gi]) + 2'(add_tail & TAIL_FULL[gi]);
      assign sum     = {1'b0, cnt_ff} + CW1'(inc);
      assign cfin    = sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0];
      assign maj[gi] = (cfin > thr);
      always_ff @(posedge clock) begin
         if (reset)       cnt_ff <= '0;
         else if (commit) cnt_ff <= ng_ctl.last ? '0 : cfin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (commit) begin
         n_ff   <= ng_ctl.last ? '0 : n_fin;
         ovf_ff <= ng_ctl.last ? 1'b0 : ovf_fin;
      end
   end

   assign res_ld.load     = commit & ng_ctl.last;
   assign res_ld.overflow = ovf_fin;

endmodule

// ===== design/hdcnb_out.sv =====
// Result buffer: holds the bundled vector and streams it out one word per item.
// Depends on hdcnb_pkg.
module hdcnb_out #(
   parameter int DIM = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [DIM-1:0]                maj,
   input  hdcnb_pkg::res_ld_type         res_ld,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [31:0]                   out_word,
   output logic [hdcnb_pkg::WIDX_W-1:0]  out_index,
   output logic                          out_last,
   output logic                          out_ovf,
   output logic                          busy
);
   import hdcnb_pkg::*;

   localparam int WORDS = DIM / 32;
   localparam int WW    = $clog2(WORDS);
   localparam logic [WW-1:0] LAST_IDX = WW'(WORDS - 1);

   logic           busy_ff;
   logic [WW-1:0]  widx_ff;
   logic [DIM-1:0] buf_ff;
   logic           ovf_ff;
   logic           hs;
   logic           at_last;

   assign hs      = busy_ff & out_ready;
   assign at_last = (widx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         widx_ff <= '0;
      end else if (res_ld.load) begin
         busy_ff <= 1'b1;
         widx_ff <= '0;
      end else if (hs) begin
         widx_ff <= widx_ff + WW'(1);
         if (at_last) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ld.load) begin
         buf_ff <= maj;
         ovf_ff <= res_ld.overflow;
      end else if (hs) begin
         buf_ff <= buf_ff >> 32;
      end
   end

   assign out_valid = busy_ff;
   assign out_word  = buf_ff[31:0];
   assign out_index = WIDX_W'(widx_ff);
   assign out_last  = at_last;
   assign out_ovf   = ovf_ff;
   assign busy      = busy_ff;

endmodule

// ===== design/hdcnb_checker.sv =====
// Port-level checks for the n-gram encoder and the bind that attaches them.
// Depends on hdcnb_pkg and hdc_ngram_encode_bundle_core.
module hdcnb_checker #(
   parameter int DIM = 1024
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hdcnb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               rsp_tuser
);
   import hdcnb_pkg::*;

   localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(DIM / 32 - 1);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // the run ends on the top word index
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[36:32] == LAST_IDX)
      else $error("last word flagged at wrong index");

   // words of a run follow without gaps, index counting up, overflow steady
   a_run_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid
         && rsp_tdata[36:32] == $past(rsp_tdata[36:32]) + 5'd1
         && rsp_tuser == $past(rsp_tuser))
      else $error("result run broken");

   // input side only backs up while a result is being delivered
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

bind hdc_ngram_encode_bundle_core hdcnb_checker #(.DIM(DIM)) u_hdcnb_checker (.*);
